// ===== sv/pgig_pkg.sv =====
package pgig_pkg;

	localparam int COORD_BITS = 32;
	localparam int POS_W      = 32;
	localparam int LEN_W      = POS_W + 1;
	localparam int SUM_W      = POS_W + 2;
	localparam int NUM_AXES   = 3;
	localparam int NUM_REGS   = 6;
	localparam int REG_W      = 64;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_COMBO  = 8;
	localparam int COMBO_W    = $clog2(NUM_COMBO);
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [REG_IDX_W-1:0] REG_X_SIM   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_OUTER_0 = REG_IDX_W'(3);

	localparam logic signed [SUM_W-1:0] COORD_MAX =
		(SUM_W'(1) <<< (COORD_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

	typedef logic signed [POS_W-1:0] coord_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][POS_W-1:0] p;
		logic [NUM_AXES-1:0][POS_W-1:0] sh;
		logic [NUM_AXES-1:0]            neg;
		logic [NUM_COMBO-1:0]           mask;
		logic                           in_box;
	} pgig_item_t;

	function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (v > COORD_MAX) r = COORD_MAX;
		if (v < COORD_MIN) r = COORD_MIN;
		return r[POS_W-1:0];
	endfunction

	// x is the most significant bit of the lexical key; a -1 axis takes its shift first
	function automatic logic [NUM_AXES-1:0] combo_use(input logic [COMBO_W-1:0] t,
			input logic [NUM_AXES-1:0] neg);
		logic [NUM_AXES-1:0] u;
		for (int a = 0; a < NUM_AXES; a++) begin
			u[a] = t[NUM_AXES-1-a] ^ neg[a];
		end
		return u;
	endfunction

endpackage

// ===== sv/pgig_front.sv =====
module pgig_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pgig_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [pgig_pkg::REG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pgig_pkg::POS_W-1:0]  pos_x,
	input  logic signed [pgig_pkg::POS_W-1:0]  pos_y,
	input  logic signed [pgig_pkg::POS_W-1:0]  pos_z,
	output logic                               push,
	output pgig_pkg::pgig_item_t               push_item,
	input  logic                               q_full
);
	import pgig_pkg::*;

	logic [REG_W-1:0]        bounds_q [NUM_REGS];
	coord_t                  pos_in [NUM_AXES];
	logic [NUM_AXES-1:0]     up, down, inside_ax;
	logic signed [LEN_W-1:0] len [NUM_AXES];

	logic                    valid_s1;
	coord_t                  p_s1 [NUM_AXES];
	logic signed [LEN_W-1:0] len_s1 [NUM_AXES];
	logic [NUM_AXES-1:0]     nz_s1, neg_s1;
	logic                    inside_s1;

	logic [NUM_AXES-1:0]     u;
	logic signed [SUM_W-1:0] step;

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) bounds_q[r] <= '0;
		end else begin
			for (int r = 0; r < NUM_REGS; r++) begin
				if (cfg_write && cfg_index == REG_X_SIM + REG_IDX_W'(r)) bounds_q[r] <= cfg_data;
			end
		end
	end

	always_comb begin
		coord_t slo, shi, olo, ohi;
		logic signed [SUM_W-1:0] p_w, up_thr, down_thr;
		for (int a = 0; a < NUM_AXES; a++) begin
			slo = bounds_q[a][POS_W-1:0];
			shi = bounds_q[a][REG_W-1:POS_W];
			olo = bounds_q[a + int'(REG_OUTER_0)][POS_W-1:0];
			ohi = bounds_q[a + int'(REG_OUTER_0)][REG_W-1:POS_W];
			p_w = SUM_W'(pos_in[a]);
			up_thr = SUM_W'(slo) + SUM_W'(ohi) - SUM_W'(shi);
			down_thr = SUM_W'(shi) + SUM_W'(olo) - SUM_W'(slo);
			up[a] = p_w < up_thr;
			down[a] = p_w > down_thr;
			inside_ax[a] = (pos_in[a] < shi) && (pos_in[a] > slo);
			len[a] = LEN_W'(shi) - LEN_W'(slo);
		end
	end

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				p_s1[a]   <= pos_in[a];
				len_s1[a] <= len[a];
			end
			nz_s1     <= up ^ down;
			neg_s1    <= down & ~up;
			inside_s1 <= &inside_ax;
		end
	end

	always_comb begin
		push_item        = '0;
		push_item.neg    = neg_s1;
		push_item.in_box = inside_s1;
		for (int a = 0; a < NUM_AXES; a++) begin
			step = neg_s1[a] ? -SUM_W'(len_s1[a]) : SUM_W'(len_s1[a]);
			push_item.p[a]  = sat_coord(SUM_W'(p_s1[a]));
			push_item.sh[a] = sat_coord(SUM_W'(p_s1[a]) + step);
		end
		for (int t = 0; t < NUM_COMBO; t++) begin
			u = combo_use(COMBO_W'(t), neg_s1);
			push_item.mask[t] = (u != '0) && ((u & ~nz_s1) == '0);
		end
	end

endmodule

// ===== sv/pgig_queue.sv =====
module pgig_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pgig_pkg::pgig_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output pgig_pkg::pgig_item_t head
);
	import pgig_pkg::*;

	pgig_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     cnt_q;

	assign full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop) rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// ===== sv/pgig_back.sv =====
module pgig_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              empty,
	input  pgig_pkg::pgig_item_t              head,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pgig_pkg::POS_W-1:0] out_x,
	output logic signed [pgig_pkg::POS_W-1:0] out_y,
	output logic signed [pgig_pkg::POS_W-1:0] out_z,
	output logic                              accepted,
	output logic                              is_image,
	output logic                              last_of_run
);
	import pgig_pkg::*;

	logic                 started_q;
	logic [NUM_COMBO-1:0] rem_q, rem_clr;
	logic [COMBO_W-1:0]   t_sel;
	logic [NUM_AXES-1:0]  u;
	logic                 fire, last;
	coord_t               res [NUM_AXES];

	always_comb begin
		t_sel = '0;
		for (int t = NUM_COMBO - 1; t >= 0; t--) begin
			if (rem_q[t]) t_sel = COMBO_W'(t);
		end
	end

	assign rem_clr = rem_q & ~(NUM_COMBO'(1) << t_sel);
	assign u       = combo_use(t_sel, head.neg);

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if (!started_q) res[a] = head.in_box ? coord_t'(head.p[a]) : '0;
			else res[a] = u[a] ? coord_t'(head.sh[a]) : coord_t'(head.p[a]);
		end
		if (!started_q) last = !head.in_box || head.mask == '0;
		else last = rem_clr == '0;
	end

	assign fire = !empty && (!out_valid || out_ready);
	assign pop  = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			rem_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fire) begin
				started_q <= !last;
				rem_q     <= started_q ? rem_clr : head.mask;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_x       <= res[0];
			out_y       <= res[1];
			out_z       <= res[2];
			accepted    <= head.in_box;
			is_image    <= started_q;
			last_of_run <= last;
		end
	end

endmodule

// ===== sv/periodic_ghost_image_generator_top.sv =====
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------------
// in        | in_valid, in_ready  | pos_x, pos_y, pos_z
// out       | out_valid, out_ready| out_x, out_y, out_z, accepted, is_image, last_of_run
// cfg       | cfg_write           | cfg_index, cfg_data
//
// An input request yields one result when rejected or with no images, and up to 8
// results with seven images; the back end emits one result per cycle unless stalled.
// The first result passes the classify register, the queue and the output register.
// A 4-entry queue between the classify stage and the emitter lets input keep flowing
// while results stall; out_ready low holds the output register.
// Reset clears the bound registers to zero and empties all stages.
module periodic_ghost_image_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [pgig_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [pgig_pkg::REG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pgig_pkg::POS_W-1:0] pos_x,
	input  logic signed [pgig_pkg::POS_W-1:0] pos_y,
	input  logic signed [pgig_pkg::POS_W-1:0] pos_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pgig_pkg::POS_W-1:0] out_x,
	output logic signed [pgig_pkg::POS_W-1:0] out_y,
	output logic signed [pgig_pkg::POS_W-1:0] out_z,
	output logic                              accepted,
	output logic                              is_image,
	output logic                              last_of_run
);
	import pgig_pkg::*;

	logic       push, q_full, pop, q_empty;
	pgig_item_t push_item, head;

	pgig_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	pgig_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	pgig_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (q_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.accepted    (accepted),
		.is_image    (is_image),
		.last_of_run (last_of_run)
	);

endmodule

// ===== sv/pgig_check.sv =====
module pgig_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [pgig_pkg::POS_W-1:0] out_x,
	input logic signed [pgig_pkg::POS_W-1:0] out_y,
	input logic signed [pgig_pkg::POS_W-1:0] out_z,
	input logic                              accepted,
	input logic                              is_image,
	input logic                              last_of_run
);
	import pgig_pkg::*;

	logic run_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_done_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			run_done_q <= last_of_run;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(is_image) && $stable(last_of_run))
		else $error("output request changed while stalled");

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> last_of_run && !is_image
			&& out_x == '0 && out_y == '0 && out_z == '0)
		else $error("rejected result malformed");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_image |-> run_done_q)
		else $error("new run started before previous run ended");

	a_image_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_image |-> accepted && !run_done_q)
		else $error("image result outside an accepted run");

endmodule

bind periodic_ghost_image_generator_top pgig_check u_pgig_check (.*);

// ===== tb/ghost_image_monitor.sv =====
module ghost_image_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [pgig_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [pgig_pkg::REG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [pgig_pkg::POS_W-1:0] pos_x,
	input  logic signed [pgig_pkg::POS_W-1:0] pos_y,
	input  logic signed [pgig_pkg::POS_W-1:0] pos_z,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [pgig_pkg::POS_W-1:0] out_x,
	input  logic signed [pgig_pkg::POS_W-1:0] out_y,
	input  logic signed [pgig_pkg::POS_W-1:0] out_z,
	input  logic                              accepted,
	input  logic                              is_image,
	input  logic                              last_of_run,
	output int                                mismatches,
	output int                                images_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [pgig_pkg::POS_W-1:0] x;
		logic signed [pgig_pkg::POS_W-1:0] y;
		logic signed [pgig_pkg::POS_W-1:0] z;
		logic                              acc;
		logic                              img;
		logic                              run_end;
	} ghost_image_t;

	logic [pgig_pkg::REG_W-1:0] bounds [pgig_pkg::NUM_REGS];
	ghost_image_t               images_q [$];
	ghost_image_t               want;

	function automatic logic [pgig_pkg::POS_W-1:0] clamp_coord(input longint v);
		longint top_v;
		longint bot_v;
		longint r;
		top_v = (longint'(1) <<< (pgig_pkg::COORD_BITS - 1)) - 1;
		bot_v = -top_v - 1;
		r = v;
		if (r > top_v) r = top_v;
		if (r < bot_v) r = bot_v;
		return r[pgig_pkg::POS_W-1:0];
	endfunction

	function automatic ghost_image_t make_image(input longint cx, cy, cz, input logic acc,
			input logic img);
		ghost_image_t g;
		g.x       = clamp_coord(cx);
		g.y       = clamp_coord(cy);
		g.z       = clamp_coord(cz);
		g.acc     = acc;
		g.img     = img;
		g.run_end = 1'b0;
		return g;
	endfunction

	task automatic predict_images(input logic [pgig_pkg::POS_W-1:0] px, py, pz);
		logic [pgig_pkg::POS_W-1:0] raw [3];
		longint       p [3];
		longint       len [3];
		int           dir [3];
		longint       slo, shi, olo, ohi;
		bit           in_box;
		bit           up, down;
		int           n;
		ghost_image_t run [8];
		raw[0] = px;
		raw[1] = py;
		raw[2] = pz;
		in_box = 1'b1;
		for (int a = 0; a < pgig_pkg::NUM_AXES; a++) begin
			slo    = longint'($signed(bounds[pgig_pkg::REG_X_SIM + a][31:0]));
			shi    = longint'($signed(bounds[pgig_pkg::REG_X_SIM + a][63:32]));
			olo    = longint'($signed(bounds[pgig_pkg::REG_OUTER_0 + a][31:0]));
			ohi    = longint'($signed(bounds[pgig_pkg::REG_OUTER_0 + a][63:32]));
			p[a]   = longint'($signed(raw[a]));
			if (!(p[a] < shi && p[a] > slo)) in_box = 1'b0;
			up     = p[a] < slo + ohi - shi;
			down   = p[a] > shi + olo - slo;
			dir[a] = int'(up) - int'(down);
			len[a] = shi - slo;
		end
		if (!in_box) begin
			run[0] = make_image(0, 0, 0, 1'b0, 1'b0);
			n = 1;
		end else begin
			run[0] = make_image(p[0], p[1], p[2], 1'b1, 1'b0);
			n = 1;
			for (int i = -1; i <= 1; i++) begin
				for (int j = -1; j <= 1; j++) begin
					for (int k = -1; k <= 1; k++) begin
						if (i == 0 && j == 0 && k == 0) continue;
						if ((i != 0 && i != dir[0]) || (j != 0 && j != dir[1]) ||
								(k != 0 && k != dir[2])) continue;
						if (n < 8) begin
							run[n] = make_image(p[0] + longint'(i) * len[0],
								p[1] + longint'(j) * len[1],
								p[2] + longint'(k) * len[2], 1'b1, 1'b1);
							n++;
						end
					end
				end
			end
		end
		run[n-1].run_end = 1'b1;
		for (int m = 0; m < n; m++) images_q.push_back(run[m]);
	endtask

	task automatic report(input string field, input logic [pgig_pkg::POS_W-1:0] exp_v,
			input logic [pgig_pkg::POS_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int r = 0; r < pgig_pkg::NUM_REGS; r++) bounds[r] = '0;
			images_q.delete();
			mismatches = 0;
			images_due = 0;
		end else begin
			if (cfg_write && cfg_index < pgig_pkg::NUM_REGS) bounds[cfg_index] = cfg_data;
			if (in_valid && in_ready) predict_images(pos_x, pos_y, pos_z);
			if (out_valid && out_ready) begin
				if (images_q.size() == 0) begin
					$display("%0t: result with no request pending, expected none actual %h %h %h %b%b%b",
						$time, out_x, out_y, out_z, accepted, is_image, last_of_run);
					mismatches++;
				end else begin
					want = images_q.pop_front();
					report("out_x", want.x, out_x);
					report("out_y", want.y, out_y);
					report("out_z", want.z, out_z);
					report("accepted", 32'(want.acc), 32'(accepted));
					report("is_image", 32'(want.img), 32'(is_image));
					report("last_of_run", 32'(want.run_end), 32'(last_of_run));
				end
			end
			images_due = images_q.size();
		end
	end

endmodule

// ===== tb/tb_periodic_ghost_image_generator_top.sv =====
module tb_periodic_ghost_image_generator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
	localparam logic [pgig_pkg::REG_IDX_W-1:0] REG_SPARE_0 =
		pgig_pkg::REG_IDX_W'(pgig_pkg::NUM_REGS);
	localparam logic [pgig_pkg::REG_IDX_W-1:0] REG_SPARE_1 =
		pgig_pkg::REG_IDX_W'(pgig_pkg::NUM_REGS + 1);

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_write;
	logic [pgig_pkg::REG_IDX_W-1:0]    cfg_index;
	logic [pgig_pkg::REG_W-1:0]        cfg_data;
	logic                              in_valid;
	logic                              in_ready;
	logic signed [pgig_pkg::POS_W-1:0] pos_x;
	logic signed [pgig_pkg::POS_W-1:0] pos_y;
	logic signed [pgig_pkg::POS_W-1:0] pos_z;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [pgig_pkg::POS_W-1:0] out_x;
	logic signed [pgig_pkg::POS_W-1:0] out_y;
	logic signed [pgig_pkg::POS_W-1:0] out_z;
	logic                              accepted;
	logic                              is_image;
	logic                              last_of_run;

	int  mismatches;
	int  images_due;
	int  cycles;
	bit  in_burst;
	bit  out_burst;
	logic [pgig_pkg::REG_W-1:0] box_regs [pgig_pkg::NUM_REGS];

	periodic_ghost_image_generator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.accepted    (accepted),
		.is_image    (is_image),
		.last_of_run (last_of_run)
	);

	ghost_image_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.accepted    (accepted),
		.is_image    (is_image),
		.last_of_run (last_of_run),
		.mismatches  (mismatches),
		.images_due  (images_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] q16(input int v);
		return v <<< 16;
	endfunction

	function automatic logic [63:0] bound_pair(input logic signed [31:0] hi, lo);
		return {hi, lo};
	endfunction

	function automatic logic signed [31:0] draw_coord(input int a);
		longint slo, shi, olo, ohi, rnd, v, w;
		int     mode;
		slo  = longint'($signed(box_regs[pgig_pkg::REG_X_SIM + a][31:0]));
		shi  = longint'($signed(box_regs[pgig_pkg::REG_X_SIM + a][63:32]));
		olo  = longint'($signed(box_regs[pgig_pkg::REG_OUTER_0 + a][31:0]));
		ohi  = longint'($signed(box_regs[pgig_pkg::REG_OUTER_0 + a][63:32]));
		rnd  = longint'($urandom);
		mode = $urandom_range(0, 23);
		if (mode == 0) begin
			v = rnd;
		end else if (mode == 1) begin
			v = $urandom_range(0, 1) ? slo : shi;
		end else if (mode < 9) begin
			w = ohi - shi;
			if (w < 0) w = 0;
			v = slo + 1 + rnd % (w + 2);
		end else if (mode < 16) begin
			w = slo - olo;
			if (w < 0) w = 0;
			v = shi - 1 - rnd % (w + 2);
		end else if (shi - slo > 1) begin
			v = slo + 1 + rnd % (shi - slo - 1);
		end else begin
			v = rnd;
		end
		return v[31:0];
	endfunction

	task automatic write_bound(input logic [pgig_pkg::REG_IDX_W-1:0] idx,
			input logic [pgig_pkg::REG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic load_bounds();
		for (int i = 0; i < pgig_pkg::NUM_REGS; i++) begin
			write_bound(pgig_pkg::REG_X_SIM + pgig_pkg::REG_IDX_W'(i), box_regs[i]);
		end
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic issue_position(input logic signed [31:0] x, y, z);
		int gap;
		if ($urandom_range(0, 11) == 0) in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x    <= x;
		pos_y    <= y;
		pos_z    <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++) begin
			issue_position(draw_coord(0), draw_coord(1), draw_coord(2));
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (images_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic random_box();
		longint slo, shi, len, mlo, mhi;
		for (int a = 0; a < pgig_pkg::NUM_AXES; a++) begin
			slo = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
			len = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(2, 32'h0100_0000)) :
				longint'($urandom_range(2, 32'h0010_0000));
			shi = slo + len;
			mlo = longint'($urandom_range(0, 32'(2 * len)));
			mhi = longint'($urandom_range(0, 32'(2 * len)));
			box_regs[pgig_pkg::REG_X_SIM + a]   = bound_pair(shi[31:0], slo[31:0]);
			box_regs[pgig_pkg::REG_OUTER_0 + a] = bound_pair(32'(shi + mlo), 32'(slo - mhi));
		end
		load_bounds();
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			if ($urandom_range(0, 11) == 0) out_burst = !out_burst;
			stall = out_burst ? 0 : $urandom_range(0, 8);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && arst_n));
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		for (int i = 0; i < pgig_pkg::NUM_REGS; i++) box_regs[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		issue_position(0, 0, 0);
		issue_position(POS_MAX, POS_MAX, POS_MAX);
		issue_position(POS_MIN, POS_MIN, POS_MIN);
		drain();

		box_regs[0] = bound_pair(q16(8), q16(-8));
		box_regs[1] = bound_pair(q16(16), q16(0));
		box_regs[2] = bound_pair(q16(-4), q16(-20));
		box_regs[3] = bound_pair(q16(10), q16(-10));
		box_regs[4] = bound_pair(q16(19), q16(-3));
		box_regs[5] = bound_pair(q16(-2), q16(-22));
		load_bounds();
		issue_position(0, q16(8), q16(-12));
		issue_position(q16(-7), q16(1), q16(-19));
		issue_position(q16(7), q16(15), q16(-5));
		issue_position(q16(-7), q16(15), q16(-12));
		issue_position(q16(-8), q16(8), q16(-12));
		issue_position(q16(8), q16(8), q16(-12));
		issue_position(q16(-8) + 1, q16(8), q16(-12));
		issue_position(0, POS_MIN, q16(-12));
		issue_position(0, POS_MAX, q16(-12));
		issue_position(0, q16(8), q16(-4) - 1);
		random_run(100);
		drain();

		for (int a = 0; a < pgig_pkg::NUM_AXES; a++) begin
			box_regs[pgig_pkg::REG_X_SIM + a]   = bound_pair(q16(1), q16(-1));
			box_regs[pgig_pkg::REG_OUTER_0 + a] = bound_pair(q16(100), q16(-100));
		end
		load_bounds();
		issue_position(0, 0, 0);
		issue_position(q16(1) - 1, q16(-1) + 1, 0);
		random_run(40);
		drain();

		for (int a = 0; a < pgig_pkg::NUM_AXES; a++) begin
			box_regs[pgig_pkg::REG_X_SIM + a]   = bound_pair(POS_MAX, POS_MIN);
			box_regs[pgig_pkg::REG_OUTER_0 + a] = bound_pair(POS_MAX, POS_MIN);
		end
		load_bounds();
		issue_position(POS_MIN + 1, POS_MAX - 1, 0);
		issue_position(POS_MIN, 0, 0);
		issue_position(0, 0, POS_MAX);
		random_run(50);
		drain();

		repeat (4) begin
			random_box();
			random_run(40);
			drain();
		end

		repeat (2) begin
			for (int i = 0; i < pgig_pkg::NUM_REGS; i++) box_regs[i] = {$urandom, $urandom};
			load_bounds();
			write_bound(REG_SPARE_0, {$urandom, $urandom});
			write_bound(REG_SPARE_1, {$urandom, $urandom});
			@(negedge clk);
			cfg_write <= 1'b0;
			random_run(15);
			drain();
		end

		box_regs[0] = bound_pair(q16(3), q16(3));
		box_regs[1] = bound_pair(q16(-5), q16(5));
		box_regs[2] = bound_pair(q16(10), q16(-10));
		box_regs[3] = bound_pair(q16(20), q16(-20));
		box_regs[4] = bound_pair(q16(20), q16(-20));
		box_regs[5] = bound_pair(q16(20), q16(-20));
		load_bounds();
		issue_position(q16(3), 0, 0);
		random_run(20);
		drain();

		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pgig_pkg.sv
sv/pgig_front.sv
sv/pgig_queue.sv
sv/pgig_back.sv
sv/periodic_ghost_image_generator_top.sv
sv/pgig_check.sv
tb/ghost_image_monitor.sv
tb/tb_periodic_ghost_image_generator_top.sv
